FILE: src/assert_macros.svh
// assertion helpers included by olist_ctrl
// expects clk and rst_n to be visible where the macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define OLIST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define OLIST_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: src/olist_pkg.sv
// ----------------------------------------------------------------------------
// olist_pkg
// Types and codes of the ordered list engine: commands, status codes and
// payload widths shared by the interfaces and the modules.
// ----------------------------------------------------------------------------
package olist_pkg;

    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    typedef logic [MODE_W-1:0]          mode_t;
    typedef logic signed [VALUE_W-1:0]  value_t;
    typedef logic [STATUS_W-1:0]        status_t;
    typedef logic [COUNT_W-1:0]         count_t;

    // command codes
    localparam mode_t MODE_APPEND    = 3'd0;
    localparam mode_t MODE_REM_HEAD  = 3'd1;
    localparam mode_t MODE_REM_TAIL  = 3'd2;
    localparam mode_t MODE_REM_MATCH = 3'd3;
    localparam mode_t MODE_DUMP      = 3'd4;

    // status codes
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_EMPTY     = 2'd1;
    localparam status_t ST_FULL      = 2'd2;
    localparam status_t ST_NOT_FOUND = 2'd3;

endpackage

FILE: src/olist_if.sv
// ----------------------------------------------------------------------------
// olist_if
// Valid/ready channels of the ordered list engine: the command channel and
// the response channel.
// ----------------------------------------------------------------------------
interface olist_cmd_if;

    logic                 valid;
    logic                 ready;
    olist_pkg::mode_t     mode;
    olist_pkg::value_t    value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);

endinterface

interface olist_rsp_if;

    logic                 valid;
    logic                 ready;
    olist_pkg::status_t   status;
    olist_pkg::value_t    entry;
    olist_pkg::count_t    count;
    logic                 is_empty;
    logic                 last;

    modport source (output valid, output status, output entry, output count,
                    output is_empty, output last, input ready);
    modport sink   (input valid, input status, input entry, input count,
                    input is_empty, input last, output ready);

endinterface

FILE: src/olist_mem.sv
// ----------------------------------------------------------------------------
// olist_mem
// Entry store of the list: one write port, one read port, registered read
// data that holds until the next read.
// ----------------------------------------------------------------------------
module olist_mem #(
    parameter int  DEPTH = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  logic [31:0]         wdata,
    input  logic                re,
    input  logic [AW-1:0]       raddr,
    output logic [31:0]         rdata
);

    logic [31:0] mem_q [DEPTH];
    logic [31:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_q[waddr] <= wdata;
        end
    end

    // read port, data registered and valid in the cycle after the read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_q[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/olist_ctrl.sv
// ----------------------------------------------------------------------------
// olist_ctrl
// Command sequencer of the ordered list engine: circular head/count
// bookkeeping, search and gap-closing passes over the entry store, dump
// sequencing and the response output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module olist_ctrl #(
    parameter int  DEPTH = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    olist_cmd_if.sink           cmd,
    olist_rsp_if.source         rsp,
    output logic                mem_we,
    output logic [AW-1:0]       mem_waddr,
    output logic [31:0]         mem_wdata,
    output logic                mem_re,
    output logic [AW-1:0]       mem_raddr,
    input  logic [31:0]         mem_rdata
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_DUMP   = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    localparam logic [AW:0]   DEPTH_CNT = (AW+1)'(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    logic [2:0]               state_reg, state_next;
    logic [AW:0]              cnt_reg, cnt_next;
    logic [AW-1:0]            head_reg, head_next;
    logic [AW-1:0]            idx_reg, idx_next;
    logic [31:0]              val_reg, val_next;
    olist_pkg::status_t       st_reg, st_next;

    logic                     ov_reg;
    olist_pkg::status_t       ostatus_reg;
    logic [31:0]              oentry_reg;
    olist_pkg::count_t        ocount_reg;
    logic                     oempty_reg;
    logic                     olast_reg;

    logic                     load;
    olist_pkg::status_t       ld_status;
    logic [31:0]              ld_entry;
    logic                     ld_last;

    logic                     out_free;
    logic [AW:0]              cnt_last;
    logic                     at_tail;
    logic [AW-1:0]            idx_inc;
    logic [AW+6:0]            cnt_ext;

    // logical position to physical address in the circular store
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [AW-1:0] offs);
        logic [AW:0] s;
        s = {1'b0, base} + {1'b0, offs};
        if (s >= DEPTH_CNT)
        begin
            s = s - DEPTH_CNT;
        end
        return s[AW-1:0];
    endfunction

    assign out_free  = !ov_reg || rsp.ready;
    assign cnt_last  = cnt_reg - 1'b1;
    assign at_tail   = ({1'b0, idx_reg} == cnt_last);
    assign idx_inc   = idx_reg + 1'b1;
    assign cnt_ext   = {6'd0, cnt_reg};
    assign cmd.ready = (state_reg == S_IDLE);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        head_next  = head_reg;
        idx_next   = idx_reg;
        val_next   = val_reg;
        st_next    = st_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        load       = 1'b0;
        ld_status  = olist_pkg::ST_OK;
        ld_entry   = '0;
        ld_last    = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    st_next    = olist_pkg::ST_OK;
                    state_next = S_RESULT;
                    case (cmd.mode)
                        olist_pkg::MODE_APPEND:
                        begin
                            if (cnt_reg == DEPTH_CNT)
                            begin
                                st_next = olist_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = phys(head_reg, cnt_reg[AW-1:0]);
                                mem_wdata = cmd.value;
                                cnt_next  = cnt_reg + 1'b1;
                            end
                        end
                        olist_pkg::MODE_REM_HEAD:
                        begin
                            if (cnt_reg == '0)
                            begin
                                st_next = olist_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                head_next = (head_reg == LAST_ADDR) ? '0 : head_reg + 1'b1;
                                cnt_next  = cnt_last;
                            end
                        end
                        olist_pkg::MODE_REM_TAIL:
                        begin
                            if (cnt_reg == '0)
                            begin
                                st_next = olist_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cnt_next = cnt_last;
                            end
                        end
                        olist_pkg::MODE_REM_MATCH, olist_pkg::MODE_DUMP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                st_next = olist_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = head_reg;
                                idx_next   = '0;
                                val_next   = cmd.value;
                                state_next = (cmd.mode == olist_pkg::MODE_DUMP) ? S_DUMP
                                                                                : S_SCAN;
                            end
                        end
                        default:
                        begin
                            st_next = olist_pkg::ST_OK;
                        end
                    endcase
                end
            end

            // compare the entry read last cycle, read the next one
            S_SCAN:
            begin
                if (at_tail)
                begin
                    state_next = S_RESULT;
                    if (mem_rdata == val_reg)
                    begin
                        cnt_next = cnt_last;
                        st_next  = olist_pkg::ST_OK;
                    end
                    else
                    begin
                        st_next = olist_pkg::ST_NOT_FOUND;
                    end
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = phys(head_reg, idx_inc);
                    idx_next  = idx_inc;
                    if (mem_rdata == val_reg)
                    begin
                        state_next = S_SHIFT;
                    end
                end
            end

            // move each later entry down one place
            S_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = phys(head_reg, idx_reg - 1'b1);
                mem_wdata = mem_rdata;
                if (at_tail)
                begin
                    cnt_next   = cnt_last;
                    st_next    = olist_pkg::ST_OK;
                    state_next = S_RESULT;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = phys(head_reg, idx_inc);
                    idx_next  = idx_inc;
                end
            end

            // one entry per cycle while the output register drains
            S_DUMP:
            begin
                if (out_free)
                begin
                    load      = 1'b1;
                    ld_status = olist_pkg::ST_OK;
                    ld_entry  = mem_rdata;
                    ld_last   = at_tail;
                    if (at_tail)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = phys(head_reg, idx_inc);
                        idx_next  = idx_inc;
                    end
                end
            end

            S_RESULT:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    ld_status  = st_reg;
                    ld_entry   = '0;
                    ld_last    = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            head_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            head_reg  <= head_next;
            if (load)
            begin
                ov_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // working and output payload registers
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        val_reg <= val_next;
        st_reg  <= st_next;
        if (load)
        begin
            ostatus_reg <= ld_status;
            oentry_reg  <= ld_entry;
            ocount_reg  <= cnt_ext[5:0];
            oempty_reg  <= (cnt_reg == '0);
            olast_reg   <= ld_last;
        end
    end

    assign rsp.valid    = ov_reg;
    assign rsp.status   = ostatus_reg;
    assign rsp.entry    = oentry_reg;
    assign rsp.count    = ocount_reg;
    assign rsp.is_empty = oempty_reg;
    assign rsp.last     = olast_reg;

    // checks
    `OLIST_ASSERT(a_cnt_bound, cnt_reg <= DEPTH_CNT, "entry count above depth")
    `OLIST_NEVER(a_rw_same, mem_we && mem_re && (mem_waddr == mem_raddr), "read and write collide")
    `OLIST_ASSERT(a_idx_range, (state_reg == S_SCAN || state_reg == S_SHIFT || state_reg == S_DUMP) |-> ({1'b0, idx_reg} < cnt_reg), "walk index past tail")
    `OLIST_ASSERT(a_busy_after_accept, (cmd.valid && cmd.ready) |=> (state_reg != S_IDLE), "accepted request left no work")

endmodule

FILE: src/ordered_list_engine_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_unit
// Bounded ordered list of signed 32-bit values held in a circular entry
// store: append, remove head, remove tail, remove first match, dump.
//
//   channel  dir  payload                               accepted when
//   cmd      in   mode, value                           valid && ready
//   rsp      out  status, entry, count, is_empty, last  valid && ready
//
// append, remove head/tail and unused codes: decoded in idle, then answered
// remove matching: entries are compared from the head; after a match each
//   later entry moves down one place to close the gap (one store read and
//   write each); an absent value gives a not-found status at the tail
// dump: one entry per cycle from the store's read port while rsp drains
// reset clears state, count, head and rsp valid; the entry store needs no clearing
// a full response register stalls the sequencer; cmd is taken in idle only
// ----------------------------------------------------------------------------
module ordered_list_engine_unit #(
    parameter int DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    olist_cmd_if.sink   cmd,
    olist_rsp_if.source rsp
);

    localparam int AW = $clog2(DEPTH);

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [31:0]         mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [31:0]         mem_rdata;

    // sequencer and response register
    olist_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // entry store
    olist_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
